>>> design/ppg_pkg.sv
// Shared types, widths and constants for the plasma pixel generator.
// No dependencies; used by every module of the block.
package ppg_pkg;

	// interface widths
	localparam int COORD_BITS = 10;
	localparam int POS_W      = 10;
	localparam int T_W        = 20;
	localparam int RW_W       = 11;
	localparam int COL_W      = 8;
	localparam int OFF_W      = 22;
	localparam int LIN_W      = 21;   // row_width*y + x

	// datapath widths (fixed point, mostly Q.16)
	localparam int P_W        = 29;   // point coordinate in Q.16
	localparam int SQ_W       = 60;   // squared distance in Q.32
	localparam int SQRT_CELLS = 30;   // one root bit per cell
	localparam int D_W        = 30;   // distance in Q.16
	localparam int A_W        = 28;   // sine argument in Q.16
	localparam int SC_W       = 61;   // scaled distance product
	localparam int PH_W       = 58;   // phase product
	localparam int U_W        = 31;   // folded phase in Q.30
	localparam int ACC_W      = 31;   // polynomial accumulator in Q.30
	localparam int SIN_W      = 18;   // signed sine in Q.16
	localparam int SUM_W      = 21;   // signed sum in Q.16
	localparam int K_W        = 4;
	localparam int LANES      = 4;

	// floor(n/7) by reciprocal multiply
	localparam logic [28:0] M7_T     = 29'd306783379;    // time, shift 31
	localparam int          M7_T_SH  = 31;
	localparam logic [30:0] M7_D     = 31'd1227133514;   // distance, shift 33
	localparam int          M7_D_SH  = 33;
	localparam logic [29:0] INV_2PI  = 30'd683565276;    // 1/(2pi) in Q.32

	localparam int HORNER_STEPS = 5;
	typedef logic [ACC_W-1:0] acc_t;
	typedef logic signed [SIN_W-1:0] sin_t;
	typedef logic [P_W-1:0] pt_t;

	localparam acc_t HORNER_SEED = 31'd3864;
	localparam acc_t HORNER_C [HORNER_STEPS] = '{
		31'd172272, 31'd5026996, 31'd85569306, 31'd693598668, 31'd1686629713
	};

	// centres in Q.16 and per-lane scaling
	localparam pt_t CENTRE_X [LANES] = '{
		29'd8388608, 29'd4194304, 29'd12582912, 29'd12582912
	};
	localparam pt_t CENTRE_Y [LANES] = '{
		29'd8388608, 29'd4194304, 29'd4194304, 29'd6553600
	};
	localparam logic LANE_DIV7 [LANES] = '{1'b0, 1'b0, 1'b1, 1'b0};

	localparam logic signed [SUM_W-1:0] SUM_BIAS = 21'sd262144;  // 4.0
	localparam logic [K_W-1:0] K_MAX = 4'd8;
	localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 11'd256;

	localparam int DIST_LAT = 3 + SQRT_CELLS;
	localparam int SINE_LAT = 5 + HORNER_STEPS;
	localparam int PIPE_LAT = 1 + DIST_LAT + SINE_LAT + 2;

endpackage

>>> design/ppg_sqrt_cell.sv
// One cell of the square root chain: settles one result bit per cycle while adv is high.
// Depends on ppg_pkg for the radicand width.
module ppg_sqrt_cell #(
	parameter int BIT_POS = 0
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [ppg_pkg::SQ_W-1:0] v_in,
	input  logic [ppg_pkg::SQ_W-1:0] r_in,
	output logic [ppg_pkg::SQ_W-1:0] v_out,
	output logic [ppg_pkg::SQ_W-1:0] r_out
);
	localparam int W = ppg_pkg::SQ_W;
	localparam logic [W-1:0] BIT = W'(1) << (2 * BIT_POS);

	logic [W-1:0] trial;
	logic [W-1:0] v_q, r_q;

	assign trial = r_in + BIT;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_in >= trial) begin
				v_q <= v_in - trial;
				r_q <= (r_in >> 1) + BIT;
			end else begin
				v_q <= v_in;
				r_q <= r_in >> 1;
			end
		end
	end

	assign v_out = v_q;
	assign r_out = r_q;
endmodule

>>> design/ppg_dist.sv
// Euclidean distance lane: abs differences, squares, then a chain of root cells.
// Depends on ppg_pkg and ppg_sqrt_cell.
module ppg_dist (
	input  logic                    clk,
	input  logic                    adv,
	input  logic [ppg_pkg::P_W-1:0] px,
	input  logic [ppg_pkg::P_W-1:0] py,
	input  logic [ppg_pkg::P_W-1:0] cx,
	input  logic [ppg_pkg::P_W-1:0] cy,
	output logic [ppg_pkg::D_W-1:0] dist_val
);
	localparam int PW = ppg_pkg::P_W;
	localparam int SW = ppg_pkg::SQ_W;
	localparam int N  = ppg_pkg::SQRT_CELLS;

	logic [PW-1:0]   dx_s1, dy_s1;
	logic [2*PW-1:0] dx2_s2, dy2_s2;
	logic [SW-1:0]   v_s3;
	logic [SW-1:0]   v_w [N+1];
	logic [SW-1:0]   r_w [N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= (px >= cx) ? px - cx : cx - px;
			dy_s1  <= (py >= cy) ? py - cy : cy - py;
			dx2_s2 <= (2*PW)'(dx_s1) * (2*PW)'(dx_s1);
			dy2_s2 <= (2*PW)'(dy_s1) * (2*PW)'(dy_s1);
			v_s3   <= SW'(dx2_s2) + SW'(dy2_s2);
		end
	end

	assign v_w[0] = v_s3;
	assign r_w[0] = '0;

	// highest power of four first
	for (genvar i = 0; i < N; i++) begin : g_cell
		ppg_sqrt_cell #(
			.BIT_POS(N - 1 - i)
		) u_cell (
			.clk  (clk),
			.adv  (adv),
			.v_in (v_w[i]),
			.r_in (r_w[i]),
			.v_out(v_w[i+1]),
			.r_out(r_w[i+1])
		);
	end

	assign dist_val = r_w[N][ppg_pkg::D_W-1:0];
endmodule

>>> design/ppg_sine.sv
// Pipelined sine of a scaled distance: scale, phase, fold, odd polynomial.
// Depends on ppg_pkg for widths and polynomial coefficients.
module ppg_sine (
	input  logic                    clk,
	input  logic                    adv,
	input  logic                    use_div7,
	input  logic [ppg_pkg::D_W-1:0] dist_val,
	output ppg_pkg::sin_t           sine
);
	localparam int SCW = ppg_pkg::SC_W;
	localparam int AW  = ppg_pkg::A_W;
	localparam int PHW = ppg_pkg::PH_W;
	localparam int UW  = ppg_pkg::U_W;
	localparam int AC  = ppg_pkg::ACC_W;
	localparam int SW  = ppg_pkg::SIN_W;
	localparam int HS  = ppg_pkg::HORNER_STEPS;
	localparam int PW2 = 2 * UW;

	logic [SCW-1:0] scale_s1;
	logic [AW-1:0]  arg;
	logic [PHW-1:0] ph_s2;
	logic [31:0]    phase;
	logic [1:0]     quad_s3, quad_s4;
	logic [UW-1:0]  u_s3, u_s4, u2_s4;
	logic [PW2-1:0] usq;

	ppg_pkg::acc_t acc_stg [HS];
	logic [UW-1:0] u2_stg  [HS];
	logic [UW-1:0] u_stg   [HS];
	logic [1:0]    quad_stg [HS];

	logic [PW2-1:0] mag_prod;
	logic [SW-1:0]  mag;
	ppg_pkg::sin_t  sine_s10;

	// both scalings land with the quotient at the same bit position
	always_ff @(posedge clk) begin
		if (adv) begin
			if (use_div7) begin
				scale_s1 <= SCW'(dist_val) * SCW'(ppg_pkg::M7_D);
			end else begin
				scale_s1 <= SCW'(dist_val >> 3) << ppg_pkg::M7_D_SH;
			end
		end
	end

	assign arg   = scale_s1[SCW-1:ppg_pkg::M7_D_SH];
	assign phase = ph_s2[47:16];
	assign usq   = PW2'(u_s3) * PW2'(u_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s2   <= PHW'(arg) * PHW'(ppg_pkg::INV_2PI);
			quad_s3 <= phase[31:30];
			// odd quadrants mirror the phase
			u_s3    <= phase[30] ? (UW'(1) << 30) - UW'(phase[29:0]) : UW'(phase[29:0]);
			quad_s4 <= quad_s3;
			u_s4    <= u_s3;
			u2_s4   <= UW'(usq >> 30);
		end
	end

	for (genvar i = 0; i < HS; i++) begin : g_horner
		ppg_pkg::acc_t  acc_in;
		logic [UW-1:0]  u2_in, u_in;
		logic [1:0]     quad_in;
		logic [PW2-1:0] prod;

		if (i == 0) begin : g_first
			assign acc_in  = ppg_pkg::HORNER_SEED;
			assign u2_in   = u2_s4;
			assign u_in    = u_s4;
			assign quad_in = quad_s4;
		end else begin : g_next
			assign acc_in  = acc_stg[i-1];
			assign u2_in   = u2_stg[i-1];
			assign u_in    = u_stg[i-1];
			assign quad_in = quad_stg[i-1];
		end

		assign prod = PW2'(acc_in) * PW2'(u2_in);

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_stg[i]  <= ppg_pkg::HORNER_C[i] - AC'(prod >> 30);
				u2_stg[i]   <= u2_in;
				u_stg[i]    <= u_in;
				quad_stg[i] <= quad_in;
			end
		end
	end

	assign mag_prod = PW2'(acc_stg[HS-1]) * PW2'(u_stg[HS-1]);
	assign mag      = SW'(mag_prod >> 44);

	always_ff @(posedge clk) begin
		if (adv) begin
			sine_s10 <= quad_stg[HS-1][1] ? -$signed(mag) : $signed(mag);
		end
	end

	assign sine = sine_s10;
endmodule

>>> design/plasma_pixel_generator_unit.sv
// Plasma pixel generator top: input stage, four distance/sine lanes, color and offset.
// Depends on ppg_pkg, ppg_dist, ppg_sine.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------
//  in       | in_valid / in_stall     | x_pos, y_pos, frame_time
//  out      | out_valid / out_stall   | red, green, blue, byte_offset
//  cfg      | cfg_valid / cfg_ready   | row_width
//
// One pixel per cycle unless the output stalls; the pipeline depth ppg_pkg::PIPE_LAT is
// set mostly by the 30-cell root chain plus the ten-stage sine pipeline per lane.
// arst_n clears the valid chain and sets row_width to 256.
// A stalled result freezes the whole pipeline; a request is taken whenever the
// last stage is empty or its result leaves in that cycle.
module plasma_pixel_generator_unit #(
	parameter int COORD_BITS = ppg_pkg::COORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ppg_pkg::POS_W-1:0]  x_pos,
	input  logic [ppg_pkg::POS_W-1:0]  y_pos,
	input  logic [ppg_pkg::T_W-1:0]    frame_time,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ppg_pkg::COL_W-1:0]  red,
	output logic [ppg_pkg::COL_W-1:0]  green,
	output logic [ppg_pkg::COL_W-1:0]  blue,
	output logic [ppg_pkg::OFF_W-1:0]  byte_offset,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ppg_pkg::RW_W-1:0]   row_width
);
	localparam int POS_W = ppg_pkg::POS_W;
	localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
	localparam int PW    = ppg_pkg::P_W;
	localparam int LW    = ppg_pkg::LIN_W;
	localparam int LAT   = ppg_pkg::PIPE_LAT;
	localparam int SUMW  = ppg_pkg::SUM_W;
	localparam int TPW   = 57;

	logic                 adv;
	logic [LAT-1:0]       valid_q;
	logic [ppg_pkg::RW_W-1:0] row_width_q;

	logic [POS_W-1:0]     x_m, y_m;
	logic [POS_W-1:0]     x_s1, y_s1;
	logic [ppg_pkg::T_W-1:0] t_s1;
	logic [TPW-1:0]       t7p_s1;
	logic [LW-1:0]        lin_pipe_q [LAT-1];

	logic [PW-1:0]        xq, yq, tq, t7;
	logic [PW-1:0]        px_l [ppg_pkg::LANES];
	logic [PW-1:0]        py_l [ppg_pkg::LANES];
	logic [ppg_pkg::D_W-1:0] dist_l [ppg_pkg::LANES];
	ppg_pkg::sin_t        sine_l [ppg_pkg::LANES];

	logic signed [SUMW-1:0] sum_s45;
	logic [ppg_pkg::K_W-1:0] k;
	logic [8:0]           color;
	logic [ppg_pkg::COL_W-1:0] red_s46, green_s46, blue_s46;
	logic [ppg_pkg::OFF_W-1:0] offset_s46;

	assign adv       = !(valid_q[LAT-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = valid_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ppg_pkg::ROW_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= row_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[LAT-2:0], in_valid};
		end
	end

	assign x_m = POS_W'(x_pos[CW-1:0]);
	assign y_m = POS_W'(y_pos[CW-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1          <= x_m;
			y_s1          <= y_m;
			t_s1          <= frame_time;
			t7p_s1        <= TPW'({frame_time, 8'b0}) * TPW'(ppg_pkg::M7_T);
			lin_pipe_q[0] <= LW'(row_width_q) * LW'(y_m) + LW'(x_m);
			for (int i = 1; i < LAT - 1; i++) begin
				lin_pipe_q[i] <= lin_pipe_q[i-1];
			end
		end
	end

	assign xq = PW'(x_s1) << 16;
	assign yq = PW'(y_s1) << 16;
	assign tq = PW'(t_s1) << 8;
	assign t7 = PW'(t7p_s1[TPW-1:ppg_pkg::M7_T_SH]);

	// lane 0 moves x with time, lane 2 moves y with time/7
	assign px_l[0] = xq + tq;
	assign py_l[0] = yq;
	assign px_l[1] = xq;
	assign py_l[1] = yq;
	assign px_l[2] = xq;
	assign py_l[2] = yq + t7;
	assign px_l[3] = xq;
	assign py_l[3] = yq;

	for (genvar l = 0; l < ppg_pkg::LANES; l++) begin : g_lane
		ppg_dist u_dist (
			.clk     (clk),
			.adv     (adv),
			.px      (px_l[l]),
			.py      (py_l[l]),
			.cx      (ppg_pkg::CENTRE_X[l]),
			.cy      (ppg_pkg::CENTRE_Y[l]),
			.dist_val(dist_l[l])
		);

		ppg_sine u_sine (
			.clk     (clk),
			.adv     (adv),
			.use_div7(ppg_pkg::LANE_DIV7[l]),
			.dist_val(dist_l[l]),
			.sine    (sine_l[l])
		);
	end

	always_comb begin
		if (sum_s45[SUMW-1]) begin
			k = '0;
		end else if (sum_s45[SUMW-2:16] > SUMW'(ppg_pkg::K_MAX)) begin
			k = ppg_pkg::K_MAX;
		end else begin
			k = ppg_pkg::K_W'(sum_s45[SUMW-2:16]);
		end
		color = {k, 5'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s45    <= SUMW'(sine_l[0]) + SUMW'(sine_l[1]) + SUMW'(sine_l[2])
			            + SUMW'(sine_l[3]) + ppg_pkg::SUM_BIAS;
			red_s46    <= color[7:0];
			green_s46  <= {color[6:0], 1'b0};
			blue_s46   <= 8'(9'd255 - color);
			offset_s46 <= ppg_pkg::OFF_W'((LW + 2)'(lin_pipe_q[LAT-2]) * (LW + 2)'(3));
		end
	end

	assign red         = red_s46;
	assign green       = green_s46;
	assign blue        = blue_s46;
	assign byte_offset = offset_s46;
endmodule
